### rtl/ccm_pkg.sv
package ccm_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_ADATA = 2'd1,
    KIND_PDATA = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OUT_CT  = 2'd0,
    OUT_TAG = 2'd1,
    OUT_REJ = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_NONCE_HIGH = 3'd2,
    REG_NONCE_LOW  = 3'd3,
    REG_NONCE_LEN  = 3'd4,
    REG_TAG_LEN    = 3'd5,
    REG_ASSOC_LEN  = 3'd6,
    REG_PAYLOAD_LEN = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ADATA  = 2'd1,
    OP_PDATA  = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 32;
  localparam int unsigned RES_MAX   = 17;
  localparam logic [31:0] ALEN_LONG = 32'd65280;
  localparam logic [3:0]  ROUNDS    = 4'd10;

  typedef struct packed {
    logic [127:0] key;
    logic [103:0] nonce;
    logic [3:0]   nonce_len;
    logic [4:0]   tag_len;
    logic [31:0]  alen;
    logic [31:0]  plen;
  } cfg_t;

  typedef struct packed {
    op_e          op;
    logic [7:0]   data;
    logic [3:0]   off;
    logic         flush;
    logic         tag;
    logic         need_ks;
    logic [127:0] key;
    logic [127:0] tmpl;
    logic [127:0] b0;
    logic [31:0]  cmask;
    logic [4:0]   tl;
    logic [47:0]  pre;
  } cmd_t;

  typedef struct packed {
    out_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    case (r)
      4'd1:    rcon = 8'h01;
      4'd2:    rcon = 8'h02;
      4'd3:    rcon = 8'h04;
      4'd4:    rcon = 8'h08;
      4'd5:    rcon = 8'h10;
      4'd6:    rcon = 8'h20;
      4'd7:    rcon = 8'h40;
      4'd8:    rcon = 8'h80;
      4'd9:    rcon = 8'h1b;
      4'd10:   rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t  = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    key_next = {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows and (unless final) MixColumns; byte 0 is most significant
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[4*c+i] = SBOX[s[127 - 8*(4*((c+i) & 3) + i) -: 8]];
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xt(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xt(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xt(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = t[i];
    end
    aes_round = r;
  endfunction

endpackage

### rtl/ccm_aes.sv
module ccm_aes import ccm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] din_i,
  input  logic [127:0] key_i,
  output logic         done_o,
  output logic [127:0] dout_o
);

  logic         run_q, done_q;
  logic [3:0]   rnd_q;
  logic [127:0] st_q, rk_q, st_n, rk_n;

  // one round per cycle, round key derived on the fly
  always_comb begin
    rk_n = key_next(rk_q, rcon(rnd_q));
    st_n = aes_round(st_q, rnd_q == ROUNDS) ^ rk_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= 4'd0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      rnd_q  <= 4'd1;
    end else if (run_q) begin
      rnd_q <= rnd_q + 4'd1;
      if (rnd_q == ROUNDS) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      st_q <= din_i ^ key_i;
      rk_q <= key_i;
    end else if (run_q) begin
      st_q <= st_n;
      rk_q <= rk_n;
    end
  end

  assign done_o = done_q;
  assign dout_o = st_q;

endmodule

### rtl/ccm_front.sv
module ccm_front import ccm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       push_i,
  output logic       full_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_byte_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_ASSOC   = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] aleft_q, aleft_d, pleft_q, pleft_d;
  logic [3:0]  off_q, off_d;
  cmd_t        cmd_d;
  cmd_t        mem_q [CMD_DEPTH];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        accept;

  logic [3:0]   nl, q, qm1;
  logic [4:0]   tl, tlm;
  logic         bad;
  logic [6:0]   nsh;
  logic [103:0] nonce_m;
  logic [31:0]  cmask;
  logic         adata;
  logic         flush_a, flush_p;

  assign full_o      = (cnt_q == 2'(CMD_DEPTH));
  assign accept      = push_i & ~full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];

  // start-time checks and block templates
  always_comb begin
    nl    = cfg_i.nonce_len;
    tl    = cfg_i.tag_len;
    q     = 4'd15 - nl;
    qm1   = q - 4'd1;
    tlm   = (tl - 5'd2) >> 1;
    adata = (cfg_i.alen != 32'd0);
    bad   = (nl < 4'd7) || (nl > 4'd13) || (tl < 5'd4) || (tl > 5'd16) || tl[0] ||
            ((nl == 4'd13) && (cfg_i.plen[31:16] != 16'd0)) ||
            ((nl == 4'd12) && (cfg_i.plen[31:24] != 8'd0));
    nsh     = {1'b0, 3'(4'd13 - nl), 3'b000};
    nonce_m = cfg_i.nonce & ({104{1'b1}} << nsh);
    if (q >= 4'd4)      cmask = 32'hffff_ffff;
    else if (q == 4'd3) cmask = 32'h00ff_ffff;
    else                cmask = 32'h0000_ffff;
    flush_a = (off_q == 4'd15) || (aleft_q == 32'd1);
    flush_p = (off_q == 4'd15) || (pleft_q == 32'd1);
  end

  always_comb begin
    phase_d = phase_q;
    aleft_d = aleft_q;
    pleft_d = pleft_q;
    off_d   = off_q;
    cmd_d   = '0;
    cmd_d.op   = OP_REJECT;
    cmd_d.data = data_byte_i;
    cmd_d.off  = off_q;
    if (kind_i == KIND_START) begin
      if (!bad) begin
        cmd_d.op    = OP_START;
        cmd_d.key   = cfg_i.key;
        cmd_d.tmpl  = {4'b0000, qm1, nonce_m, 16'h0000};
        cmd_d.b0    = {1'b0, adata, tlm[2:0], qm1[2:0], nonce_m, 16'h0000} |
                      {96'd0, cfg_i.plen & cmask};
        cmd_d.cmask = cmask;
        cmd_d.tl    = tl;
        aleft_d     = cfg_i.alen;
        pleft_d     = cfg_i.plen;
        off_d       = 4'd0;
        if (adata) begin
          phase_d = PH_ASSOC;
          if (cfg_i.alen < ALEN_LONG) begin
            cmd_d.pre = {cfg_i.alen[15:0], 32'd0};
            off_d     = 4'd2;
          end else begin
            cmd_d.pre = {8'hff, 8'hfe, cfg_i.alen};
            off_d     = 4'd6;
          end
        end else if (cfg_i.plen != 32'd0) begin
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d   = PH_IDLE;
          cmd_d.tag = 1'b1;
        end
      end
    end else if ((kind_i == KIND_ADATA) && (phase_q == PH_ASSOC)) begin
      cmd_d.op    = OP_ADATA;
      cmd_d.flush = flush_a;
      aleft_d     = aleft_q - 32'd1;
      off_d       = flush_a ? 4'd0 : off_q + 4'd1;
      if (aleft_q == 32'd1) begin
        if (pleft_q != 32'd0) begin
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d   = PH_IDLE;
          cmd_d.tag = 1'b1;
        end
      end
    end else if ((kind_i == KIND_PDATA) && (phase_q == PH_PAYLOAD)) begin
      cmd_d.op      = OP_PDATA;
      cmd_d.flush   = flush_p;
      cmd_d.need_ks = (off_q == 4'd0);
      pleft_d       = pleft_q - 32'd1;
      off_d         = flush_p ? 4'd0 : off_q + 4'd1;
      if (pleft_q == 32'd1) begin
        phase_d   = PH_IDLE;
        cmd_d.tag = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      aleft_q <= 32'd0;
      pleft_q <= 32'd0;
      off_q   <= 4'd0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        aleft_q <= aleft_d;
        pleft_q <= pleft_d;
        off_q   <= off_d;
        wp_q    <= ~wp_q;
      end
      if (cmd_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, accept} - {1'b0, cmd_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wp_q] <= cmd_d;
    end
  end

endmodule

### rtl/ccm_back.sv
module ccm_back import ccm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_B0   = 6'b000010,
    B_S0   = 6'b000100,
    B_KS   = 6'b001000,
    B_MAC  = 6'b010000,
    B_TAG  = 6'b100000
  } bstate_e;

  localparam int unsigned PW = $clog2(OUT_DEPTH);

  bstate_e      state_q, state_d;
  cmd_t         cur_q, cur_d;
  logic [127:0] mac_q, mac_d, tm_q, tm_d, buf_q, buf_d, ks_q, ks_d;
  logic [127:0] tmpl_q, tmpl_d, key_q, key_d;
  logic [31:0]  cmask_q, cmask_d, cnt_q, cnt_d;
  logic [4:0]   tl_q, tl_d;
  logic [3:0]   idx_q, idx_d;

  logic         aes_start, aes_done;
  logic [127:0] aes_din, aes_key, aes_dout;

  logic         res_push;
  res_t         res_d;
  res_t         fifo_q [OUT_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]  ocnt_q;
  logic         opop;

  logic         in_ks;
  logic [7:0]   fb_byte;
  logic [3:0]   fb_off;
  logic         fb_flush;
  logic [127:0] buf_w, ks_src, ctr_blk;
  logic [7:0]   ct;

  // the byte being finished comes from the queue head, or from the held
  // command once its keystream block is ready
  always_comb begin
    in_ks    = (state_q == B_KS);
    fb_byte  = in_ks ? cur_q.data : cmd_i.data;
    fb_off   = in_ks ? cur_q.off : cmd_i.off;
    fb_flush = in_ks ? cur_q.flush : cmd_i.flush;
    ks_src   = in_ks ? aes_dout : ks_q;
    buf_w    = buf_q;
    buf_w[{~fb_off, 3'b000} +: 8] = fb_byte;
    ct       = fb_byte ^ ks_src[{~fb_off, 3'b000} +: 8];
    ctr_blk  = {tmpl_q[127:32], (tmpl_q[31:0] & ~cmask_q) | (cnt_q & cmask_q)};
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    mac_d     = mac_q;
    tm_d      = tm_q;
    buf_d     = buf_q;
    ks_d      = ks_q;
    tmpl_d    = tmpl_q;
    key_d     = key_q;
    cmask_d   = cmask_q;
    cnt_d     = cnt_q;
    tl_d      = tl_q;
    idx_d     = idx_q;
    cmd_pop_o = 1'b0;
    aes_start = 1'b0;
    aes_din   = buf_w ^ mac_q;
    aes_key   = key_q;
    res_push  = 1'b0;
    res_d     = '0;
    res_d.kind = OUT_REJ;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i && (ocnt_q <= (PW+1)'(OUT_DEPTH - RES_MAX))) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          case (cmd_i.op)
            OP_START: begin
              key_d     = cmd_i.key;
              tmpl_d    = cmd_i.tmpl;
              cmask_d   = cmd_i.cmask;
              tl_d      = cmd_i.tl;
              cnt_d     = 32'd1;
              buf_d     = {cmd_i.pre, 80'd0};
              aes_start = 1'b1;
              aes_din   = cmd_i.b0;
              aes_key   = cmd_i.key;
              state_d   = B_B0;
            end
            OP_ADATA, OP_PDATA: begin
              if ((cmd_i.op == OP_PDATA) && cmd_i.need_ks) begin
                aes_start = 1'b1;
                aes_din   = ctr_blk;
                state_d   = B_KS;
              end else begin
                if (cmd_i.op == OP_PDATA) begin
                  res_push   = 1'b1;
                  res_d.kind = OUT_CT;
                  res_d.data = ct;
                end
                if (fb_flush) begin
                  buf_d     = '0;
                  aes_start = 1'b1;
                  state_d   = B_MAC;
                end else begin
                  buf_d = buf_w;
                end
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      B_B0: begin
        if (aes_done) begin
          mac_d     = aes_dout;
          aes_start = 1'b1;
          aes_din   = tmpl_q;
          state_d   = B_S0;
        end
      end
      B_S0: begin
        if (aes_done) begin
          tm_d    = aes_dout;
          idx_d   = 4'd0;
          state_d = cur_q.tag ? B_TAG : B_IDLE;
        end
      end
      B_KS: begin
        if (aes_done) begin
          ks_d       = aes_dout;
          cnt_d      = cnt_q + 32'd1;
          res_push   = 1'b1;
          res_d.kind = OUT_CT;
          res_d.data = ct;
          if (fb_flush) begin
            buf_d     = '0;
            aes_start = 1'b1;
            state_d   = B_MAC;
          end else begin
            buf_d   = buf_w;
            state_d = B_IDLE;
          end
        end
      end
      B_MAC: begin
        if (aes_done) begin
          mac_d   = aes_dout;
          idx_d   = 4'd0;
          state_d = cur_q.tag ? B_TAG : B_IDLE;
        end
      end
      B_TAG: begin
        res_push   = 1'b1;
        res_d.kind = OUT_TAG;
        res_d.data = mac_q[{~idx_q, 3'b000} +: 8] ^ tm_q[{~idx_q, 3'b000} +: 8];
        res_d.last = ({1'b0, idx_q} == (tl_q - 5'd1));
        idx_d      = idx_q + 4'd1;
        if (res_d.last) begin
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  ccm_aes u_aes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (aes_start),
    .din_i   (aes_din),
    .key_i   (aes_key),
    .done_o  (aes_done),
    .dout_o  (aes_dout)
  );

  assign empty_o = (ocnt_q == '0);
  assign opop    = pop_i & ~empty_o;
  assign res_o   = fifo_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= 32'd0;
      tl_q    <= 5'd0;
      idx_q   <= 4'd0;
      mac_q   <= '0;
      tm_q    <= '0;
      buf_q   <= '0;
      ks_q    <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
      ocnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tl_q    <= tl_d;
      idx_q   <= idx_d;
      mac_q   <= mac_d;
      tm_q    <= tm_d;
      buf_q   <= buf_d;
      ks_q    <= ks_d;
      if (res_push) begin
        wp_q <= wp_q + PW'(1);
      end
      if (opop) begin
        rp_q <= rp_q + PW'(1);
      end
      ocnt_q <= ocnt_q + {{PW{1'b0}}, res_push} - {{PW{1'b0}}, opop};
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    tmpl_q  <= tmpl_d;
    key_q   <= key_d;
    cmask_q <= cmask_d;
    if (res_push) begin
      fifo_q[wp_q] <= res_d;
    end
  end

endmodule

### rtl/aes128_ccm_encrypt_core.sv
// Flow: a data byte that needs a new keystream block waits for the AES unit to make it,
//   and a start's first tag byte waits for the B0 and S0 blocks.
// Throughput: one request per cycle into the front queue while full is low; the back end
//   finishes bytes at one per cycle while it waits on no AES block and the result queue
//   has room; the shared AES unit runs per 16-byte block for keystream and for the MAC.
// Reset: rst_ni is asynchronous, active low; it empties both queues, idles the sequencer
//   and returns the configuration registers to their defaults (nonce 13, tag 16 bytes).
module aes128_ccm_encrypt_core import ccm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // Configuration registers; snapshotted by the front end when a start is accepted,
  // so later writes only affect the next message.
  logic [63:0] key_high_q, key_low_q, nonce_low_q;
  logic [39:0] nonce_high_q;
  logic [3:0]  nonce_len_q;
  logic [4:0]  tag_len_q;
  logic [31:0] alen_q, plen_q;
  logic        cfg_we;

  cfg_t cfg;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q   <= 64'd0;
      key_low_q    <= 64'd0;
      nonce_high_q <= 40'd0;
      nonce_low_q  <= 64'd0;
      nonce_len_q  <= 4'd13;
      tag_len_q    <= 5'd16;
      alen_q       <= 32'd0;
      plen_q       <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_KEY_HIGH:    key_high_q   <= cfg_data_i;
        REG_KEY_LOW:     key_low_q    <= cfg_data_i;
        REG_NONCE_HIGH:  nonce_high_q <= cfg_data_i[39:0];
        REG_NONCE_LOW:   nonce_low_q  <= cfg_data_i;
        REG_NONCE_LEN:   nonce_len_q  <= cfg_data_i[3:0];
        REG_TAG_LEN:     tag_len_q    <= cfg_data_i[4:0];
        REG_ASSOC_LEN:   alen_q       <= cfg_data_i[31:0];
        REG_PAYLOAD_LEN: plen_q       <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.key       = {key_high_q, key_low_q};
    cfg.nonce     = {nonce_high_q, nonce_low_q};
    cfg.nonce_len = nonce_len_q;
    cfg.tag_len   = tag_len_q;
    cfg.alen      = alen_q;
    cfg.plen      = plen_q;
  end

  // Front end: checks each request against the message phase, tracks byte counts and
  // block offsets, and queues a fully classified command.
  ccm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .push_i      (push),
    .full_o      (full),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: runs the CBC-MAC and CTR blocks on the shared round unit and fills the
  // result queue; it only takes a command when the queue can hold a full tag burst.
  ccm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign out_kind_o = res.kind;
  assign out_byte_o = res.data;
  assign last_o     = res.last;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ccm_pkg::*;

  // kind code the block must refuse, outside kind_e
  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam int unsigned IDLE_LIMIT = 3000;
  // keep a margin for a start to finish before register writes
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef enum int {PH_IDLE, PH_ASSOC, PH_PAYLOAD} msg_phase_e;
  typedef logic [0:15][7:0] blk_t;

  // directed table row: a register write, or a request with an optional typed answer
  typedef struct {
    bit          is_cfg;
    reg_e        idx;
    logic [63:0] val;
    logic [1:0]  kind;
    logic [7:0]  dat;
    bit          typed;
    out_kind_e   ekind;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind_r = KIND_START;
  logic [7:0]  data_r = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = 64'd0;

  aes128_ccm_encrypt_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .kind_i      (kind_r),
    .data_byte_i (data_r),
    .empty       (empty),
    .pop         (pop),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register copies as the block should hold them, plus message state
  // ---------------------------------------------------------------------------
  logic [63:0] c_key_hi = '0, c_key_lo = '0, c_nonce_lo = '0;
  logic [39:0] c_nonce_hi = '0;
  logic [3:0]  c_nlen = 4'd13;
  logic [4:0]  c_tlen = 5'd16;
  logic [31:0] c_alen = '0, c_plen = '0;

  logic [0:175][7:0] rkey;
  blk_t        mac, bbuf, kst, tmask, ctrb;
  int unsigned bctr, boff, cbytes, tlen;
  logic [31:0] aleft, pleft;
  msg_phase_e  pphase = PH_IDLE;

  res_t        ccm_expected[$];
  int unsigned errors = 0;
  int unsigned mism = 0;
  int unsigned n_items = 0;

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t aes_encrypt(input blk_t din);
    blk_t s, t;
    logic [7:0] a0, a1, a2, a3, x;
    for (int i = 0; i < 16; i++) s[i] = din[i] ^ rkey[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 4; i++) t[4*c+i] = SBOX[s[4*((c+i) & 3)+i]];
      end
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          x  = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkey[16*r+i];
    end
    return s;
  endfunction

  task automatic expand_key();
    logic [7:0] rc, tw[4], tmp;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rkey[i]   = 8'(c_key_hi >> (56 - 8*i));
      rkey[i+8] = 8'(c_key_lo >> (56 - 8*i));
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) tw[j] = rkey[i-4+j];
      if ((i & 15) == 0) begin
        tmp   = tw[0];
        tw[0] = SBOX[tw[1]] ^ rc;
        tw[1] = SBOX[tw[2]];
        tw[2] = SBOX[tw[3]];
        tw[3] = SBOX[tmp];
        rc    = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) rkey[i+j] = rkey[i-16+j] ^ tw[j];
    end
  endtask

  task automatic mac_fold();
    mac  = aes_encrypt(bbuf ^ mac);
    bbuf = '0;
    boff = 0;
  endtask

  task automatic emit_tag();
    for (int i = 0; i < tlen && i < 16; i++)
      ccm_expected.push_back('{OUT_TAG, mac[i] ^ tmask[i], (i + 1 == tlen)});
    pphase = PH_IDLE;
  endtask

  task automatic start_msg();
    int unsigned q;
    blk_t b0;
    // refused starts leave every piece of state alone
    if (c_nlen < 7 || c_nlen > 13 || c_tlen < 4 || c_tlen > 16 || c_tlen[0]) begin
      ccm_expected.push_back('{OUT_REJ, 8'h00, 1'b0});
      return;
    end
    q = 15 - c_nlen;
    if (q < 4 && (c_plen >> (8*q)) != 0) begin
      ccm_expected.push_back('{OUT_REJ, 8'h00, 1'b0});
      return;
    end
    expand_key();
    tlen   = c_tlen;
    cbytes = q;
    ctrb   = '0;
    ctrb[0] = 8'(q - 1);
    for (int i = 0; i < c_nlen; i++)
      ctrb[1+i] = (i < 5) ? 8'(c_nonce_hi >> (32 - 8*i)) : 8'(c_nonce_lo >> (56 - 8*(i-5)));
    b0 = ctrb;
    b0[0] = {1'b0, (c_alen != 0), 3'((tlen - 2) >> 1), 3'(q - 1)};
    for (int i = 0; i < q && i < 4; i++) b0[15-i] = 8'(c_plen >> (8*i));
    mac   = aes_encrypt(b0);
    tmask = aes_encrypt(ctrb);
    bbuf  = '0;
    kst   = '0;
    bctr  = 1;
    boff  = 0;
    aleft = c_alen;
    pleft = c_plen;
    if (aleft != 0) begin
      // short or long associated-length prefix
      if (aleft < 32'd65280) begin
        bbuf[0] = aleft[15:8];
        bbuf[1] = aleft[7:0];
        boff = 2;
      end else begin
        bbuf[0] = 8'hff;
        bbuf[1] = 8'hfe;
        for (int i = 0; i < 4; i++) bbuf[2+i] = 8'(aleft >> (24 - 8*i));
        boff = 6;
      end
      pphase = PH_ASSOC;
    end else if (pleft != 0) begin
      pphase = PH_PAYLOAD;
    end else begin
      emit_tag();
    end
  endtask

  task automatic predict_ccm(input logic [1:0] k, input logic [7:0] d);
    if (k == KIND_START) begin
      start_msg();
    end else if (k == KIND_ADATA && pphase == PH_ASSOC) begin
      bbuf[boff & 15] = d;
      boff++;
      aleft--;
      if (boff >= 16 || aleft == 0) mac_fold();
      if (aleft == 0) begin
        if (pleft != 0) pphase = PH_PAYLOAD;
        else emit_tag();
      end
    end else if (k == KIND_PDATA && pphase == PH_PAYLOAD) begin
      if (boff == 0) begin
        for (int i = 0; i < cbytes && i < 4; i++) ctrb[15-i] = 8'(bctr >> (8*i));
        kst = aes_encrypt(ctrb);
        bctr++;
      end
      ccm_expected.push_back('{OUT_CT, d ^ kst[boff & 15], 1'b0});
      bbuf[boff & 15] = d;
      boff++;
      pleft--;
      if (boff >= 16 || pleft == 0) mac_fold();
      if (pleft == 0) emit_tag();
    end else begin
      ccm_expected.push_back('{OUT_REJ, 8'h00, 1'b0});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request side: bursts with random gaps; a request lands on the edge where
  // push is high and full low. Every driving task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;

  task automatic send_req(input logic [1:0] k, input logic [7:0] d, input bit typed,
                          input out_kind_e ek);
    int unsigned gap, n_before;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push   <= 1'b1;
    kind_r <= k;
    data_r <= d;
    @(posedge clk);
    while (full) @(posedge clk);
    n_before = ccm_expected.size();
    predict_ccm(k, d);
    if (typed) begin
      // reject answers are plain: replace the predicted entry by the typed one
      while (ccm_expected.size() > n_before) void'(ccm_expected.pop_back());
      ccm_expected.push_back('{ek, 8'h00, 1'b0});
    end
    n_items++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [1:0] k, input logic [7:0] d);
    send_req(k, d, 1'b0, OUT_CT);
  endtask

  // hold off until every result is back and the back end has gone quiet
  task automatic drain_wait();
    push <= 1'b0;
    burst_left = 0;
    while (ccm_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_KEY_HIGH:    c_key_hi   = val;
      REG_KEY_LOW:     c_key_lo   = val;
      REG_NONCE_HIGH:  c_nonce_hi = val[39:0];
      REG_NONCE_LOW:   c_nonce_lo = val;
      REG_NONCE_LEN:   c_nlen     = val[3:0];
      REG_TAG_LEN:     c_tlen     = val[4:0];
      REG_ASSOC_LEN:   c_alen     = val[31:0];
      REG_PAYLOAD_LEN: c_plen     = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] pick_wide();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // noise that the block must refuse during the current phase
  function automatic logic [1:0] wrong_kind(input msg_phase_e ph);
    if ($urandom_range(0, 2) == 0) return KIND_BAD;
    return (ph == PH_ASSOC) ? KIND_PDATA : KIND_ADATA;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern is drawn from four modes and redrawn periodically over the cycles
  // ---------------------------------------------------------------------------
  int unsigned cyc = 0;
  int unsigned pop_mode = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    cyc <= cyc + 1;
    if ((cyc & 255) == 0) pop_mode <= $urandom_range(0, 3);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pop <= 1'b0;
    end else begin
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        2: begin
          if ($urandom_range(0, 19) == 0) begin
            stall_left <= $urandom_range(5, 20);
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
          end
        end
        default: pop <= ((cyc % 3) == 0);
      endcase
    end
  end

  // checker and watchdog
  int unsigned quiet = 0;
  res_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
      if (pop && !empty) begin
        if (ccm_expected.size() == 0) begin
          errors++;
          if (mism < 10)
            $display("unexpected result kind=%0d byte=%h last=%0d",
                     out_kind_o, out_byte_o, last_o);
          mism++;
        end else begin
          want = ccm_expected.pop_front();
          if (out_kind_o !== want.kind || out_byte_o !== want.data || last_o !== want.last) begin
            errors++;
            if (mism < 10)
              $display("mismatch: exp kind=%0d byte=%h last=%0d, got kind=%0d byte=%h last=%0d",
                       want.kind, want.data, want.last, out_kind_o, out_byte_o, last_o);
            mism++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[36];

  initial begin
    int unsigned nb, r, fed;
    bit cut;

    // refusals straight after reset, then the empty message under reset values
    dir_rows[0]  = '{0, REG_KEY_HIGH, 0, KIND_ADATA, 8'h00, 1, OUT_REJ};
    dir_rows[1]  = '{0, REG_KEY_HIGH, 0, KIND_BAD,   8'hff, 1, OUT_REJ};
    dir_rows[2]  = '{0, REG_KEY_HIGH, 0, KIND_PDATA, 8'hff, 1, OUT_REJ};
    dir_rows[3]  = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 0, OUT_TAG};
    // nonce length outside 7..13
    dir_rows[4]  = '{1, REG_NONCE_LEN, 64'd6, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[5]  = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 1, OUT_REJ};
    dir_rows[6]  = '{1, REG_NONCE_LEN, 64'd15, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[7]  = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 1, OUT_REJ};
    // odd and oversized tag lengths
    dir_rows[8]  = '{1, REG_NONCE_LEN, 64'd13, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[9]  = '{1, REG_TAG_LEN, 64'd5, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[10] = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 1, OUT_REJ};
    dir_rows[11] = '{1, REG_TAG_LEN, 64'd18, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[12] = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 1, OUT_REJ};
    // payload length too wide for a 2-byte counter
    dir_rows[13] = '{1, REG_TAG_LEN, 64'd4, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[14] = '{1, REG_PAYLOAD_LEN, 64'd65536, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[15] = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 1, OUT_REJ};
    // all-ones key and nonce, short message with both data kinds
    dir_rows[16] = '{1, REG_PAYLOAD_LEN, 64'd2, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[17] = '{1, REG_KEY_HIGH, '1, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[18] = '{1, REG_KEY_LOW, '1, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[19] = '{1, REG_NONCE_HIGH, '1, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[20] = '{1, REG_NONCE_LOW, '1, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[21] = '{1, REG_ASSOC_LEN, 64'd3, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[22] = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 0, OUT_TAG};
    dir_rows[23] = '{0, REG_KEY_HIGH, 0, KIND_ADATA, 8'hff, 0, OUT_TAG};
    dir_rows[24] = '{0, REG_KEY_HIGH, 0, KIND_ADATA, 8'h00, 0, OUT_TAG};
    dir_rows[25] = '{0, REG_KEY_HIGH, 0, KIND_ADATA, 8'hff, 0, OUT_TAG};
    dir_rows[26] = '{0, REG_KEY_HIGH, 0, KIND_PDATA, 8'h00, 0, OUT_TAG};
    dir_rows[27] = '{0, REG_KEY_HIGH, 0, KIND_PDATA, 8'hff, 0, OUT_TAG};
    // shortest nonce, long associated-length form, maximum payload length;
    // the message is abandoned by a fresh start
    dir_rows[28] = '{1, REG_NONCE_LEN, 64'd7, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[29] = '{1, REG_ASSOC_LEN, 64'hffff_ffff, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[30] = '{1, REG_PAYLOAD_LEN, 64'hffff_ffff, KIND_START, 8'h00, 0, OUT_REJ};
    dir_rows[31] = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 0, OUT_TAG};
    dir_rows[32] = '{0, REG_KEY_HIGH, 0, KIND_ADATA, 8'h5a, 0, OUT_TAG};
    dir_rows[33] = '{0, REG_KEY_HIGH, 0, KIND_PDATA, 8'ha5, 1, OUT_REJ};
    dir_rows[34] = '{0, REG_KEY_HIGH, 0, KIND_START, 8'h00, 0, OUT_TAG};
    dir_rows[35] = '{0, REG_KEY_HIGH, 0, KIND_ADATA, 8'h3c, 0, OUT_TAG};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_wait();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_req(dir_rows[i].kind, dir_rows[i].dat, dir_rows[i].typed, dir_rows[i].ekind);
      end
    end

    // random messages: mostly well formed, some noise, cut-offs and bad setups
    while (n_items < 180) begin
      drain_wait();
      write_reg(REG_KEY_HIGH, pick_wide());
      write_reg(REG_KEY_LOW, pick_wide());
      write_reg(REG_NONCE_HIGH, pick_wide());
      write_reg(REG_NONCE_LOW, pick_wide());
      write_reg(REG_NONCE_LEN, 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(7, 13)));
      write_reg(REG_TAG_LEN, 64'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                            : 2 * $urandom_range(2, 8)));
      r = $urandom_range(0, 19);
      if (r < 4) nb = 0;
      else if (r < 18) nb = $urandom_range(1, 24);
      else if (r == 18) nb = $urandom_range(25, 70);
      else nb = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 65280 + $urandom_range(0, 1000);
      write_reg(REG_ASSOC_LEN, 64'(nb));
      r = $urandom_range(0, 19);
      write_reg(REG_PAYLOAD_LEN, 64'((r == 0) ? 65536 + $urandom_range(0, 9) :
                                     (r < 4)  ? 0 : $urandom_range(1, 40)));
      cut = ($urandom_range(0, 19) == 0);

      send_byte(KIND_START, 8'($urandom));
      // associated bytes; a long message, or one left open by a refused start,
      // is fed a few and then dropped
      fed = 0;
      while (pphase == PH_ASSOC) begin
        if ($urandom_range(0, 15) == 0) send_byte(wrong_kind(pphase), 8'($urandom));
        send_byte(KIND_ADATA, 8'($urandom));
        fed++;
        if (aleft > 32'd1000 && fed > 4) break;
      end
      if (pphase == PH_ASSOC) continue;
      while (pphase == PH_PAYLOAD) begin
        if ($urandom_range(0, 15) == 0) send_byte(wrong_kind(pphase), 8'($urandom));
        send_byte(KIND_PDATA, 8'($urandom));
        if (cut && pleft == 1) break;
      end
      // stray request once the message is closed or cut off
      if ($urandom_range(0, 7) == 0) send_byte(wrong_kind(pphase), 8'($urandom));
    end

    drain_wait();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### aes128_ccm_encrypt_core.f
rtl/ccm_pkg.sv
rtl/ccm_aes.sv
rtl/ccm_front.sv
rtl/ccm_back.sv
rtl/aes128_ccm_encrypt_core.sv
verif/testbench.sv
